// ----- rtl/doip_pkg.sv -----
// shared types and constants for the doip diagnostic response parser
package doip_pkg;

  // frame layout
  localparam int HDR_BYTES = 8;
  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  // header and response constants
  localparam logic [7:0]  PROTO_VERSION = 8'h02;
  localparam logic [7:0]  PROTO_INVERSE = 8'hFD;
  localparam logic [15:0] DIAG_MSG_TYPE = 16'h8001;
  localparam logic [7:0]  UDS_RDBI_POS = 8'h62;

  // reset values of the configuration registers
  localparam logic [15:0] LOCAL_ADDR_RST = 16'h0B00;
  localparam logic [15:0] PEER_ADDR_RST  = 16'h0E00;
  localparam logic [15:0] DID_RST        = 16'hF191;

  // fahrenheit conversion: x / 5 as (x * RECIP5) >> RECIP5_SHIFT, then one correction
  localparam int          CONV_W       = 20;
  localparam int          RECIP5_SHIFT = 22;
  localparam logic [19:0] RECIP5       = 20'd838860;
  localparam logic [19:0] F_OFFSET     = 20'd162;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_VERSION = 3'd1,
    ST_BAD_TYPE    = 3'd2,
    ST_BAD_LENGTH  = 3'd3,
    ST_NO_MATCH    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_FAHRENHEIT = 2'd0,
    CFG_LOCAL_ADDR = 2'd1,
    CFG_PEER_ADDR  = 2'd2,
    CFG_DID        = 2'd3
  } cfg_index_t;

  // one classified frame result on its way to the back end
  typedef struct packed {
    status_t     status;
    logic [15:0] temp;
    logic        fahr;
  } doip_entry_t;

  // configuration seen by the front end
  typedef struct packed {
    logic        fahrenheit_mode;
    logic [15:0] local_address;
    logic [15:0] peer_address;
    logic [15:0] data_identifier;
  } doip_cfg_t;

endpackage

// ----- rtl/doip_front.sv -----
// byte parser: header and payload checks, one classified result per frame
module doip_front import doip_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  doip_cfg_t   cfg,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  output logic        push,
  output doip_entry_t push_entry
);

  logic [8:0]  byte_position;
  logic        header_ok;
  logic [15:0] type_accum;
  logic [31:0] length_accum;
  logic        match_ok;
  logic [15:0] temp_accum;

  logic [8:0]  byte_position_next;
  logic        header_ok_next;
  logic [15:0] type_accum_next;
  logic [31:0] length_accum_next;
  logic        match_ok_next;
  logic [15:0] temp_accum_next;

  logic        in_header;
  logic [8:0]  pay_pos;
  logic [31:0] len_full;
  logic [7:0]  expect_byte;
  logic        check_byte;
  logic        match_now;
  logic [15:0] temp_now;
  logic        frame_end;
  logic        restart;

  assign in_header = byte_position < 9'(HDR_BYTES);
  assign pay_pos   = byte_position - 9'(HDR_BYTES);
  assign len_full  = {length_accum[23:0], rx_byte};

  // expected payload byte for the address and response fields
  always_comb begin
    expect_byte = 8'h00;
    check_byte  = 1'b1;
    case (pay_pos)
      9'd0: expect_byte = cfg.peer_address[15:8];
      9'd1: expect_byte = cfg.peer_address[7:0];
      9'd2: expect_byte = cfg.local_address[15:8];
      9'd3: expect_byte = cfg.local_address[7:0];
      9'd4: expect_byte = UDS_RDBI_POS;
      9'd5: expect_byte = cfg.data_identifier[15:8];
      9'd6: expect_byte = cfg.data_identifier[7:0];
      default: check_byte = 1'b0;
    endcase
  end

  assign match_now = match_ok && !(check_byte && (rx_byte != expect_byte));
  assign temp_now  = (pay_pos == 9'd7 || pay_pos == 9'd8) ?
                     {temp_accum[7:0], rx_byte} : temp_accum;
  assign frame_end = !in_header &&
                     ({1'b0, byte_position} >= (10'(length_accum[7:0]) + 10'd7));

  always_comb begin
    push               = 1'b0;
    push_entry.status  = ST_OK;
    push_entry.temp    = 16'h0000;
    push_entry.fahr    = 1'b0;
    restart            = 1'b0;
    byte_position_next = byte_position + 9'd1;
    header_ok_next     = header_ok;
    type_accum_next    = type_accum;
    length_accum_next  = length_accum;
    match_ok_next      = match_ok;
    temp_accum_next    = temp_accum;

    if (in_header) begin
      if (byte_position == 9'd0 && rx_byte != PROTO_VERSION) header_ok_next = 1'b0;
      if (byte_position == 9'd1 && rx_byte != PROTO_INVERSE) header_ok_next = 1'b0;
      if (byte_position == 9'd2 || byte_position == 9'd3) begin
        type_accum_next = {type_accum[7:0], rx_byte};
      end
      if (byte_position >= 9'd4) length_accum_next = len_full;
      if (byte_position == 9'(HDR_BYTES - 1)) begin
        if (!header_ok) begin
          push              = 1'b1;
          push_entry.status = ST_BAD_VERSION;
        end else if (type_accum != DIAG_MSG_TYPE) begin
          push              = 1'b1;
          push_entry.status = ST_BAD_TYPE;
        end else if (len_full < 32'd4 || len_full > 32'(MAX_PAYLOAD)) begin
          push              = 1'b1;
          push_entry.status = ST_BAD_LENGTH;
        end
        restart = push;
      end
    end else begin
      match_ok_next   = match_now;
      temp_accum_next = temp_now;
      if (frame_end) begin
        push    = 1'b1;
        restart = 1'b1;
        if (match_now && length_accum[7:0] >= 8'd9) begin
          push_entry.status = ST_OK;
          push_entry.temp   = temp_now;
          push_entry.fahr   = cfg.fahrenheit_mode;
        end else begin
          push_entry.status = ST_NO_MATCH;
        end
      end
    end

    if (restart) begin
      byte_position_next = 9'd0;
      header_ok_next     = 1'b1;
      type_accum_next    = 16'h0000;
      length_accum_next  = 32'h0000_0000;
      match_ok_next      = 1'b1;
      temp_accum_next    = 16'h0000;
    end

    if (!accept) push = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 9'd0;
      header_ok     <= 1'b1;
      type_accum    <= 16'h0000;
      length_accum  <= 32'h0000_0000;
      match_ok      <= 1'b1;
      temp_accum    <= 16'h0000;
    end else if (accept) begin
      byte_position <= byte_position_next;
      header_ok     <= header_ok_next;
      type_accum    <= type_accum_next;
      length_accum  <= length_accum_next;
      match_ok      <= match_ok_next;
      temp_accum    <= temp_accum_next;
    end
  end

endmodule

// ----- rtl/doip_queue.sv -----
// short result queue between the parser and the conversion pipeline
module doip_queue import doip_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  doip_entry_t push_entry,
  input  logic        pop,
  output doip_entry_t head,
  output logic        empty,
  output logic        full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  doip_entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) count <= count + CNT_W'(1);
      else if (!push && pop) count <= count - CNT_W'(1);
    end
  end

endmodule

// ----- rtl/doip_back.sv -----
// three-stage result pipeline with fahrenheit conversion and output register
module doip_back import doip_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  doip_entry_t head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [16:0] temperature,
  output logic        in_fahrenheit
);

  logic advance;

  // stage a: 9t + 162
  logic              a_valid;
  doip_entry_t       a_entry;
  logic [CONV_W-1:0] a_x;

  // stage b: quotient estimate
  logic              b_valid;
  doip_entry_t       b_entry;
  logic [CONV_W-1:0] b_x;
  logic [16:0]       b_q;

  logic [CONV_W-1:0]   x_calc;
  logic [2*CONV_W-1:0] prod;
  logic [CONV_W-1:0]   rem;
  logic [16:0]         q_fix;

  assign advance = !out_valid || !out_stall;
  assign pop     = advance && !empty;

  assign x_calc = {1'b0, head.temp, 3'b000} + CONV_W'(head.temp) + F_OFFSET;
  assign prod   = (2*CONV_W)'(a_x) * (2*CONV_W)'(RECIP5);
  // estimate is the quotient or one short of it
  assign rem    = b_x - ({3'b000, b_q} + {1'b0, b_q, 2'b00});
  assign q_fix  = (rem >= CONV_W'(5)) ? b_q + 17'd1 : b_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      a_valid   <= pop;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_entry       <= head;
      a_x           <= x_calc;
      b_entry       <= a_entry;
      b_x           <= a_x;
      b_q           <= prod[RECIP5_SHIFT +: 17];
      status        <= b_entry.status;
      in_fahrenheit <= b_entry.fahr;
      temperature   <= b_entry.fahr ? q_fix : {1'b0, b_entry.temp};
    end
  end

endmodule

// ----- rtl/doip_diag_response_parser.sv -----
// top level of the doip diagnostic response parser
//
// takes a received doip stream one byte per beat and checks the 8-byte header
// (version 0x02, inverse 0xfd, payload type 0x8001, length 4 to MAX_PAYLOAD),
// then the payload: source address against peer_address, target address
// against local_address, a 0x62 positive response and the data_identifier,
// followed by a 16-bit big-endian temperature. one result beat comes out per
// frame: status 0 with the temperature (fahrenheit as floor((9t+162)/5) when
// fahrenheit_mode is set, sampled at the frame's last byte), status 4 when the
// response does not match or is shorter than 9 payload bytes, or status 1, 2 or
// 3 at the eighth header byte for a bad version, type or length, after which
// parsing restarts at a new header. fields other than status read 0 unless the
// status is 0. a byte is taken every cycle while in_stall is low. the parser
// and the conversion pipeline are joined by a QUEUE_DEPTH-entry result queue,
// and in_stall rises only when that queue is full, i.e. when out_stall has held
// results back for a while. configuration is written through cfg_write,
// cfg_index and cfg_data and should only change between frames.
module doip_diag_response_parser import doip_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [16:0] temperature,
  output logic        in_fahrenheit
);

  doip_cfg_t   cfg;
  logic        accept;
  logic        push;
  doip_entry_t push_entry;
  logic        pop;
  doip_entry_t head;
  logic        empty;
  logic        full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fahrenheit_mode <= 1'b0;
      cfg.local_address   <= LOCAL_ADDR_RST;
      cfg.peer_address    <= PEER_ADDR_RST;
      cfg.data_identifier <= DID_RST;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_FAHRENHEIT: cfg.fahrenheit_mode <= cfg_data[0];
        CFG_LOCAL_ADDR: cfg.local_address   <= cfg_data;
        CFG_PEER_ADDR:  cfg.peer_address    <= cfg_data;
        CFG_DID:        cfg.data_identifier <= cfg_data;
        default: ;
      endcase
    end
  end

  // a byte can always be taken unless its result might find the queue full
  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  // front: byte parsing and classification
  doip_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .rx_byte    (rx_byte),
    .push       (push),
    .push_entry (push_entry)
  );

  // result queue decoupling the parser from the output side
  doip_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  // back: conversion pipeline and output register
  doip_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .temperature   (temperature),
    .in_fahrenheit (in_fahrenheit)
  );

endmodule

// ----- tb/sv/tb_doip_diag_response_parser.sv -----
// testbench for the doip diagnostic response parser: byte stimulus, reading predictor, checks
`timescale 1ns / 1ps

module tb_doip_diag_response_parser;
  import doip_pkg::*;

  localparam int MAX_PAYLOAD = MAX_PAYLOAD_DEF;
  // least number of input bytes queued per phase, extreme frames included
  localparam int BYTES_PER_PHASE = 175;
  localparam int NUM_PHASES = 8;
  // throttle percentages for the pacing modes
  localparam int IDLE_PCT = 83;
  localparam int BOTH_PCT = 13;
  // wait after the last predicted reading; give the pipeline some slack
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 500000;

  typedef enum int {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

  typedef enum int {
    FRAME_GOOD, FRAME_SHORT, FRAME_BAD_FIELD, FRAME_BAD_VERSION,
    FRAME_BAD_INVERSE, FRAME_BAD_TYPE, FRAME_BAD_LENGTH, FRAME_NOISE
  } frame_kind_t;

  // one predicted result beat
  typedef struct {
    status_t     status;
    logic [16:0] temperature;
    logic        fahr;
  } reading_t;

  // byte-serial predictor of the parser plus the queue of readings it predicts
  class reading_scoreboard;
    // local copy of the configuration registers
    bit        fahr_mode;
    bit [15:0] local_addr;
    bit [15:0] peer_addr;
    bit [15:0] did;
    // parse state
    int unsigned pos;
    bit          hdr_good;
    bit [15:0]   msg_type;
    bit [31:0]   pay_len;
    bit          resp_good;
    bit [15:0]   temp_raw;
    reading_t    expected_readings[$];
    int          errors;

    function new();
      fahr_mode = 1'b0;
      local_addr = LOCAL_ADDR_RST;
      peer_addr = PEER_ADDR_RST;
      did = DID_RST;
      errors = 0;
      restart();
    endfunction

    function void restart();
      pos = 0;
      hdr_good = 1'b1;
      msg_type = '0;
      pay_len = '0;
      resp_good = 1'b1;
      temp_raw = '0;
    endfunction

    function void set_reg(cfg_index_t idx, bit [15:0] val);
      case (idx)
        CFG_FAHRENHEIT: fahr_mode = val[0];
        CFG_LOCAL_ADDR: local_addr = val;
        CFG_PEER_ADDR:  peer_addr = val;
        CFG_DID:        did = val;
        default: ;
      endcase
    endfunction

    function bit frame_idle();
      return pos == 0;
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    function void push_reading(status_t st, bit [16:0] t, bit f);
      reading_t r;
      r.status = st;
      r.temperature = t;
      r.fahr = f;
      expected_readings.push_back(r);
    endfunction

    // advance the parser by one accepted input beat
    function void note_byte(bit [7:0] b);
      int unsigned p;
      int unsigned t;
      status_t st;
      if (pos < HDR_BYTES) begin
        if (pos == 0 && b != PROTO_VERSION) hdr_good = 1'b0;
        if (pos == 1 && b != PROTO_INVERSE) hdr_good = 1'b0;
        if (pos == 2 || pos == 3) msg_type = {msg_type[7:0], b};
        if (pos >= 4) pay_len = {pay_len[23:0], b};
        if (pos == HDR_BYTES - 1) begin
          // version beats type beats length
          st = ST_OK;
          if (!hdr_good) st = ST_BAD_VERSION;
          else if (msg_type != DIAG_MSG_TYPE) st = ST_BAD_TYPE;
          else if (pay_len < 4 || pay_len > MAX_PAYLOAD) st = ST_BAD_LENGTH;
          if (st != ST_OK) begin
            push_reading(st, '0, 1'b0);
            restart();
            return;
          end
        end
        pos++;
        return;
      end
      p = pos - HDR_BYTES;
      case (p)
        0: if (b != peer_addr[15:8]) resp_good = 1'b0;
        1: if (b != peer_addr[7:0]) resp_good = 1'b0;
        2: if (b != local_addr[15:8]) resp_good = 1'b0;
        3: if (b != local_addr[7:0]) resp_good = 1'b0;
        4: if (b != UDS_RDBI_POS) resp_good = 1'b0;
        5: if (b != did[15:8]) resp_good = 1'b0;
        6: if (b != did[7:0]) resp_good = 1'b0;
        7, 8: temp_raw = {temp_raw[7:0], b};
        default: ;
      endcase
      if (p + 1 >= pay_len) begin
        if (resp_good && pay_len >= 9) begin
          t = temp_raw;
          if (fahr_mode) t = (9 * t + 162) / 5;
          push_reading(ST_OK, t[16:0], fahr_mode);
        end else begin
          push_reading(ST_NO_MATCH, '0, 1'b0);
        end
        restart();
        return;
      end
      pos++;
    endfunction

    // compare one accepted result beat with the oldest prediction
    function void check_reading(logic [2:0] st, logic [16:0] t, logic f);
      reading_t r;
      if (expected_readings.size() == 0) begin
        $error("result beat with no reading expected: status %0d temperature %0d", st, t);
        errors++;
        return;
      end
      r = expected_readings.pop_front();
      if (st !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, st);
        errors++;
      end
      if (t !== r.temperature) begin
        $error("temperature: expected %0d, got %0d", r.temperature, t);
        errors++;
      end
      if (f !== r.fahr) begin
        $error("in_fahrenheit: expected %0d, got %0d", r.fahr, f);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [16:0] temperature;
  logic        in_fahrenheit;

  reading_scoreboard sb;
  logic [7:0]  tx_bytes[$];
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int unsigned cycle_count = 0;

  doip_diag_response_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .temperature  (temperature),
    .in_fahrenheit(in_fahrenheit)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("doip_diag_response_parser: mismatch");
      $finish;
    end
  end

  // result side: check accepted beats, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_reading(status, temperature, in_fahrenheit);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // offer one byte, with random idle cycles ahead of it, and wait for acceptance;
  // valid stays high afterwards so back-to-back beats never toggle it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_byte(b);
  endtask

  task automatic send_stream();
    while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
  endtask

  // register write; the caller drops cfg_write after the last one
  task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  function automatic void queue_header(logic [7:0] ver, logic [7:0] inv, logic [15:0] ptype,
                                       logic [31:0] len);
    tx_bytes.push_back(ver);
    tx_bytes.push_back(inv);
    tx_bytes.push_back(ptype[15:8]);
    tx_bytes.push_back(ptype[7:0]);
    tx_bytes.push_back(len[31:24]);
    tx_bytes.push_back(len[23:16]);
    tx_bytes.push_back(len[15:8]);
    tx_bytes.push_back(len[7:0]);
  endfunction

  // payload that matches the current configuration, except one corrupted byte at bad_at
  function automatic void queue_payload(int len, int bad_at, logic [15:0] temp);
    logic [7:0] b;
    for (int p = 0; p < len; p++) begin
      case (p)
        0: b = sb.peer_addr[15:8];
        1: b = sb.peer_addr[7:0];
        2: b = sb.local_addr[15:8];
        3: b = sb.local_addr[7:0];
        4: b = UDS_RDBI_POS;
        5: b = sb.did[15:8];
        6: b = sb.did[7:0];
        7: b = temp[15:8];
        8: b = temp[7:0];
        default: b = $urandom;
      endcase
      if (p == bad_at) b = b ^ 8'($urandom_range(1, 255));
      tx_bytes.push_back(b);
    end
  endfunction

  function automatic void queue_good(int len, logic [15:0] temp);
    queue_header(PROTO_VERSION, PROTO_INVERSE, DIAG_MSG_TYPE, len);
    queue_payload(len, -1, temp);
  endfunction

  function automatic logic [15:0] pick_temp();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_bad_length();
    case ($urandom_range(5))
      0: return $urandom_range(0, 3);
      1: return $urandom_range(MAX_PAYLOAD + 1, 255);
      2: return 32'hFFFF_FFFF;
      // low byte in range, upper bytes not
      3: return {8'($urandom_range(1, 255)), 16'($urandom), 8'($urandom_range(4, MAX_PAYLOAD))};
      default: return 32'($urandom) | 32'h0000_0100;
    endcase
  endfunction

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 55) return FRAME_GOOD;
    if (r < 62) return FRAME_SHORT;
    if (r < 74) return FRAME_BAD_FIELD;
    if (r < 78) return FRAME_BAD_VERSION;
    if (r < 81) return FRAME_BAD_INVERSE;
    if (r < 87) return FRAME_BAD_TYPE;
    if (r < 94) return FRAME_BAD_LENGTH;
    return FRAME_NOISE;
  endfunction

  function automatic void queue_frame(frame_kind_t kind);
    int len;
    logic [15:0] ptype;
    case (kind)
      FRAME_GOOD: begin
        len = ($urandom_range(3) == 0) ? $urandom_range(9, MAX_PAYLOAD) : $urandom_range(9, 12);
        queue_good(len, pick_temp());
      end
      FRAME_SHORT: begin
        // too short for a reading, content matching or not
        len = $urandom_range(4, 8);
        queue_header(PROTO_VERSION, PROTO_INVERSE, DIAG_MSG_TYPE, len);
        queue_payload(len, $urandom_range(1) ? -1 : $urandom_range(0, len - 1), pick_temp());
      end
      FRAME_BAD_FIELD: begin
        len = $urandom_range(9, 14);
        queue_header(PROTO_VERSION, PROTO_INVERSE, DIAG_MSG_TYPE, len);
        queue_payload(len, $urandom_range(0, 6), pick_temp());
      end
      FRAME_BAD_VERSION: begin
        // sometimes with a bad type as well: version must win
        ptype = $urandom_range(1) ? DIAG_MSG_TYPE : 16'($urandom);
        queue_header(PROTO_VERSION ^ 8'($urandom_range(1, 255)), PROTO_INVERSE, ptype,
                     $urandom_range(4, MAX_PAYLOAD));
      end
      FRAME_BAD_INVERSE: begin
        queue_header(PROTO_VERSION, PROTO_INVERSE ^ 8'($urandom_range(1, 255)), DIAG_MSG_TYPE,
                     $urandom_range(0, 300));
      end
      FRAME_BAD_TYPE: begin
        // sometimes with a bad length as well: type must win
        queue_header(PROTO_VERSION, PROTO_INVERSE, DIAG_MSG_TYPE ^ 16'($urandom_range(1, 65535)),
                     $urandom_range(1) ? $urandom_range(4, MAX_PAYLOAD) : pick_bad_length());
      end
      FRAME_BAD_LENGTH: begin
        queue_header(PROTO_VERSION, PROTO_INVERSE, DIAG_MSG_TYPE, pick_bad_length());
      end
      default: begin
        // stray bytes that knock the parser off frame alignment
        len = $urandom_range(1, 12);
        repeat (len) tx_bytes.push_back(8'($urandom));
      end
    endcase
  endfunction

  // edge cases run under the reset configuration
  task automatic directed_frames();
    queue_good(9, 16'h0000);
    queue_good(MAX_PAYLOAD, 16'hFFFF);
    queue_good(10, 16'h1234);
    // short responses end in no-match even when every byte agrees
    queue_good(4, 16'h0000);
    queue_good(8, 16'h0000);
    // one wrong byte in each compared payload field
    for (int i = 0; i < 7; i++) begin
      queue_header(PROTO_VERSION, PROTO_INVERSE, DIAG_MSG_TYPE, 9);
      queue_payload(9, i, 16'h00FF);
    end
    queue_header(8'h00, PROTO_INVERSE, DIAG_MSG_TYPE, 9);
    queue_header(PROTO_VERSION, 8'h02, DIAG_MSG_TYPE, 9);
    queue_header(8'hFF, PROTO_INVERSE, 16'h0000, 0);
    queue_header(PROTO_VERSION, PROTO_INVERSE, 16'h0180, 9);
    queue_header(PROTO_VERSION, PROTO_INVERSE, DIAG_MSG_TYPE, 0);
    queue_header(PROTO_VERSION, PROTO_INVERSE, DIAG_MSG_TYPE, 3);
    queue_header(PROTO_VERSION, PROTO_INVERSE, DIAG_MSG_TYPE, MAX_PAYLOAD + 1);
    queue_header(PROTO_VERSION, PROTO_INVERSE, DIAG_MSG_TYPE, 32'hFFFF_FFFF);
    send_stream();
  endtask

  // settings per phase: extremes first, then random ones
  task automatic configure_phase(int ph);
    case (ph)
      1: begin
        write_reg(CFG_FAHRENHEIT, 16'h0001);
        write_reg(CFG_LOCAL_ADDR, 16'h0000);
        write_reg(CFG_PEER_ADDR, 16'hFFFF);
        write_reg(CFG_DID, 16'h0000);
      end
      2: begin
        write_reg(CFG_FAHRENHEIT, 16'h0000);
        write_reg(CFG_LOCAL_ADDR, 16'hFFFF);
        write_reg(CFG_PEER_ADDR, 16'h0000);
        write_reg(CFG_DID, 16'hFFFF);
      end
      3: begin
        // fahrenheit with the reset addresses; upper data bits are don't-care
        write_reg(CFG_FAHRENHEIT, 16'hFFFF);
        write_reg(CFG_LOCAL_ADDR, LOCAL_ADDR_RST);
        write_reg(CFG_PEER_ADDR, PEER_ADDR_RST);
        write_reg(CFG_DID, DID_RST);
      end
      default: begin
        write_reg(CFG_FAHRENHEIT, {15'($urandom), 1'(ph)});
        write_reg(CFG_LOCAL_ADDR, 16'($urandom));
        write_reg(CFG_PEER_ADDR, 16'($urandom));
        write_reg(CFG_DID, 16'($urandom));
      end
    endcase
    cfg_write <= 1'b0;
  endtask

  task automatic set_pace(pace_t pace);
    case (pace)
      PACE_FREE: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      PACE_SENDER: begin
        send_idle_pct = IDLE_PCT;
        stall_pct = 0;
      end
      PACE_RECEIVER: begin
        send_idle_pct = 0;
        stall_pct = IDLE_PCT;
      end
      default: begin
        send_idle_pct = BOTH_PCT;
        stall_pct = BOTH_PCT;
      end
    endcase
  endtask

  // wait for every predicted reading, then let the pipeline settle
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= CFG_FAHRENHEIT;
    cfg_data <= '0;
    in_valid <= 1'b0;
    rx_byte <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) configure_phase(ph);
      set_pace(pace_t'(ph % 4));
      if (ph == 0) directed_frames();
      // temperature extremes under each setting
      queue_good(9, 16'h0000);
      queue_good(9, 16'hFFFF);
      while (tx_bytes.size() < BYTES_PER_PHASE) queue_frame(pick_kind());
      send_stream();
      // finish any partial frame so the parser sits at a header before a register write
      while (!sb.frame_idle()) send_byte(8'($urandom));
      in_valid <= 1'b0;
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("doip_diag_response_parser: match");
    else
      $display("doip_diag_response_parser: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/doip_pkg.sv
rtl/doip_front.sv
rtl/doip_queue.sv
rtl/doip_back.sv
rtl/doip_diag_response_parser.sv
tb/sv/tb_doip_diag_response_parser.sv
